// ----- hw/rtl/mves_pkg.sv -----
package mves_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned PRICE_W      = 10;
  localparam int unsigned OCC_W        = 7;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    func_e              func;
    logic [KIND_W-1:0]  item_kind;
    logic [PRICE_W-1:0] price;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [KIND_W-1:0]  taken_kind;
    logic [PRICE_W-1:0] taken_price;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PRICE_W-1:0] price;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    capture;
    logic    write_ins;
    logic    scan_init;
    logic    scan_issue;
    logic    shift_init;
    logic    shift_issue;
    logic    emit;
    logic    inc;
    logic    dec;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic more;
  } stat_t;

endpackage

// ----- hw/rtl/mves_ram.sv -----
module mves_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mves_ctrl.sv -----
module mves_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  input  mves_pkg::stat_t stat_i,
  output mves_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SETUP,
    S_SHIFT
  } state_e;

  state_e         state_q, state_d;
  logic           done_q;
  mves_pkg::cmd_t cmd;

  always_comb begin
    cmd     = '0;
    cmd.status = mves_pkg::ST_DONE;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.capture = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat_i.is_remove) begin
          cmd.emit = 1'b1;
          if (stat_i.full) begin
            cmd.status = mves_pkg::ST_FULL;
          end else begin
            cmd.write_ins = 1'b1;
            cmd.inc       = 1'b1;
          end
          state_d = S_IDLE;
        end else if (stat_i.empty) begin
          cmd.emit   = 1'b1;
          cmd.status = mves_pkg::ST_EMPTY;
          state_d    = S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.shift_init = 1'b1;
        state_d        = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat_i.more) begin
          cmd.shift_issue = 1'b1;
        end else begin
          cmd.emit = 1'b1;
          cmd.dec  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd.emit;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign cmd_o  = cmd;

endmodule

// ----- hw/rtl/mves_datapath.sv -----
module mves_datapath #(
  parameter int unsigned CAPACITY = mves_pkg::CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mves_pkg::req_t  req_i,
  input  mves_pkg::cmd_t  cmd_i,
  output mves_pkg::stat_t stat_o,
  output mves_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  mves_pkg::req_t   req_q;
  mves_pkg::rsp_t   rsp_q;
  mves_pkg::entry_t best_q, rd_entry, wr_entry;
  logic [CW-1:0]    count_q, count_d, ptr_q;
  logic [AW-1:0]    scan_idx_q, best_idx_q, wr_addr_q, waddr;
  logic             scan_vld_q, shift_vld_q, we;
  logic [mves_pkg::ENTRY_W-1:0] rdata;

  assign rd_entry = mves_pkg::entry_t'(rdata);

  always_comb begin
    we       = cmd_i.write_ins | shift_vld_q;
    waddr    = wr_addr_q;
    wr_entry = rd_entry;
    if (cmd_i.write_ins) begin
      waddr          = count_q[AW-1:0];
      wr_entry.kind  = req_q.item_kind;
      wr_entry.price = req_q.price;
    end
  end

  mves_ram #(
    .WIDTH (mves_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_vld_q  <= 1'b0;
      shift_vld_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_vld_q  <= cmd_i.scan_issue;
      shift_vld_q <= cmd_i.shift_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_init) begin
      ptr_q <= '0;
    end else if (cmd_i.shift_init) begin
      ptr_q <= CW'(best_idx_q) + CW'(1);
    end else if (cmd_i.scan_issue || cmd_i.shift_issue) begin
      ptr_q <= ptr_q + CW'(1);
    end
    if (cmd_i.scan_issue) begin
      scan_idx_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.shift_issue) begin
      wr_addr_q <= ptr_q[AW-1:0] - AW'(1);
    end
    // earliest entry wins on equal price
    if (scan_vld_q && ((scan_idx_q == '0) || (rd_entry.price > best_q.price))) begin
      best_q     <= rd_entry;
      best_idx_q <= scan_idx_q;
    end
    if (cmd_i.emit) begin
      rsp_q.status      <= cmd_i.status;
      rsp_q.taken_kind  <= cmd_i.dec ? best_q.kind : '0;
      rsp_q.taken_price <= cmd_i.dec ? best_q.price : '0;
      rsp_q.occupancy   <= mves_pkg::OCC_W'(count_d);
    end
  end

  assign stat_o.is_remove = (req_q.func == mves_pkg::FUNC_REMOVE);
  assign stat_o.full      = (count_q >= CW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.more      = (ptr_q < count_q);
  assign rsp_o            = rsp_q;

endmodule

// ----- hw/rtl/max_value_extract_store_unit.sv -----
// Bounded store of (kind, price) entries. An insert request appends an entry;
// a full store drops it with status full. A remove request scans the store
// oldest first through the single read port of the entry memory, returns the
// highest-priced entry (earliest wins a tie) and closes the gap by moving
// later entries down one place a cycle. busy_o is high while a request is in
// hand; the result appears for one cycle with done_o and must be captured
// then, as the receiver cannot stall it.
module max_value_extract_store_unit #(
  parameter int unsigned CAPACITY = mves_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  mves_pkg::req_t req_i,
  output logic           done_o,
  output mves_pkg::rsp_t result_o
);

  mves_pkg::cmd_t  cmd;
  mves_pkg::stat_t stat;

  mves_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  mves_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (result_o)
  );

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mves_pkg::*;

  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t rsp;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 25;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b1, '{ST_EMPTY, 3'd0, 10'd0, 7'd0}},
    '{'{FUNC_INSERT, 3'd0, 10'd0},    1'b1, '{ST_DONE, 3'd0, 10'd0, 7'd1}},
    '{'{FUNC_REMOVE, 3'd5, 10'd7},    1'b1, '{ST_DONE, 3'd0, 10'd0, 7'd0}},
    '{'{FUNC_REMOVE, 3'd7, 10'd1023}, 1'b1, '{ST_EMPTY, 3'd0, 10'd0, 7'd0}},
    '{'{FUNC_INSERT, 3'd7, 10'd1023}, 1'b1, '{ST_DONE, 3'd0, 10'd0, 7'd1}},
    '{'{FUNC_INSERT, 3'd6, 10'd1001}, 1'b0, '0},
    '{'{FUNC_INSERT, 3'd5, 10'd1000}, 1'b0, '0},
    '{'{FUNC_INSERT, 3'd3, 10'd500},  1'b0, '0},
    '{'{FUNC_INSERT, 3'd4, 10'd500},  1'b0, '0},
    '{'{FUNC_INSERT, 3'd2, 10'd1023}, 1'b0, '0},
    '{'{FUNC_INSERT, 3'd1, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b1, '{ST_DONE, 3'd7, 10'd1023, 7'd6}},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b1, '{ST_EMPTY, 3'd0, 10'd0, 7'd0}},
    '{'{FUNC_INSERT, 3'd0, 10'd5},    1'b0, '0},
    '{'{FUNC_INSERT, 3'd1, 10'd5},    1'b0, '0},
    '{'{FUNC_INSERT, 3'd2, 10'd5},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0},
    '{'{FUNC_REMOVE, 3'd0, 10'd0},    1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  rsp_t result_o;

  entry_t shelf[$];
  rsp_t   awaited[$];
  int     faults = 0;

  max_value_extract_store_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // highest price wins, earliest entry on a tie; later entries close up
  function automatic rsp_t apply_request(req_t r);
    rsp_t   o;
    entry_t e;
    int     top;
    o = '0;
    o.status = ST_DONE;
    if (r.func == FUNC_INSERT) begin
      if (shelf.size() >= CAPACITY_DEF) begin
        o.status = ST_FULL;
      end else begin
        e.kind  = r.item_kind;
        e.price = r.price;
        shelf.insert(shelf.size(), e);
      end
    end else if (shelf.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      top = 0;
      for (int i = 1; i < shelf.size(); i++) begin
        if (shelf[i].price > shelf[top].price) top = i;
      end
      o.taken_kind  = shelf[top].kind;
      o.taken_price = shelf[top].price;
      shelf.delete(top);
    end
    o.occupancy = OCC_W'(shelf.size());
    return o;
  endfunction

  function automatic req_t draw_request(int fill_pct);
    req_t r;
    int   pick;
    r.func      = ($urandom_range(99) < fill_pct) ? FUNC_INSERT : FUNC_REMOVE;
    r.item_kind = KIND_W'($urandom_range(7));
    pick = $urandom_range(9);
    if (pick < 6) begin
      r.price = PRICE_W'($urandom_range(1000));
    end else if (pick < 8) begin
      r.price = PRICE_W'($urandom_range(15)); // dense ties
    end else begin
      r.price = PRICE_W'($urandom_range(1023, 1001));
    end
    return r;
  endfunction

  task automatic flag(string what, rsp_t want, rsp_t got);
    faults++;
    if (faults <= 10) begin
      $display("%0t %s: exp st=%0d k=%0d p=%0d occ=%0d, got st=%0d k=%0d p=%0d occ=%0d",
               $time, what, want.status, want.taken_kind, want.taken_price, want.occupancy,
               got.status, got.taken_kind, got.taken_price, got.occupancy);
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(req_t r, logic fixed, rsp_t given);
    rsp_t want;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    want = apply_request(r);
    awaited.insert(awaited.size(), fixed ? given : want);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(int pct);
    if ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    rsp_t want;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        flag("unexpected result", '0, result_o);
      end else begin
        want = awaited.pop_front();
        if (result_o.status !== want.status || result_o.taken_kind !== want.taken_kind ||
            result_o.taken_price !== want.taken_price ||
            result_o.occupancy !== want.occupancy) begin
          flag("result mismatch", want, result_o);
        end
      end
    end
  end

  initial begin
    int phase_idle [5];
    int fill_pct;
    int left;
    phase_idle = '{0, 65, 27, 65, 0};
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    fill_pct = 50;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      send_request(PLAN[i].req, PLAN[i].fixed, PLAN[i].rsp);
    end

    // bursts of fill-heavy and drain-heavy requests reach both full and empty
    foreach (phase_idle[ph]) begin
      left = 0;
      for (int n = 0; n < 250; n++) begin
        if (left == 0) begin
          left = $urandom_range(100, 10);
          case ($urandom_range(3))
            0: fill_pct = 100;
            1: fill_pct = 85;
            2: fill_pct = 50;
            default: fill_pct = 15;
          endcase
        end
        left--;
        pause_sender(phase_idle[ph]);
        send_request(draw_request(fill_pct), 1'b0, '0);
      end
    end
    start_i <= 1'b0;

    while (awaited.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY_DEF + 16) @(posedge clk_i);
    if (faults == 0 && awaited.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
